// ===== hdl/fragmented_mp4_box_splitter_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the fragmented MP4 box splitter.
// Each macro expands to one labelled concurrent assertion, clocked on the
// rising edge and switched off while the asynchronous reset is asserted.
// ---------------------------------------------------------------------------
`ifndef FRAGMENTED_MP4_BOX_SPLITTER_MACROS_SVH
`define FRAGMENTED_MP4_BOX_SPLITTER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FMBS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fmbs assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define FMBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fmbs assertion failed");

`endif

// ===== hdl/fmbs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// fmbs_pkg
// Types, box type tags and the box classifier of the fragmented MP4 box
// splitter.
// ---------------------------------------------------------------------------
package fmbs_pkg;

	localparam int unsigned HdrBytes = 8;
	localparam int unsigned ShiftW   = 8 * (HdrBytes - 1);

	typedef logic [3:0]  hdr_cnt_t;
	typedef logic [31:0] box_len_t;
	typedef logic [31:0] box_tag_t;

	localparam box_tag_t TAG_FTYP = 32'h6674_7970;
	localparam box_tag_t TAG_MOOV = 32'h6d6f_6f76;
	localparam box_tag_t TAG_MOOF = 32'h6d6f_6f66;
	localparam box_tag_t TAG_MDAT = 32'h6d64_6174;
	localparam box_tag_t TAG_STYP = 32'h7374_7970;
	localparam box_tag_t TAG_SIDX = 32'h7369_6478;
	localparam box_tag_t TAG_PRFT = 32'h7072_6674;
	localparam box_tag_t TAG_FREE = 32'h6672_6565;

	localparam hdr_cnt_t HDR_LAST = hdr_cnt_t'(HdrBytes - 1);
	localparam hdr_cnt_t HDR_DONE = hdr_cnt_t'(HdrBytes);
	localparam box_len_t MIN_BOX  = box_len_t'(HdrBytes);

	typedef enum logic [2:0] {
		CLS_OTHER = 3'd0,
		CLS_FTYP  = 3'd1,
		CLS_MOOV  = 3'd2,
		CLS_LEAD  = 3'd3,
		CLS_MOOF  = 3'd4,
		CLS_MDAT  = 3'd5
	} box_class_t;

	function automatic box_class_t classify(input box_tag_t box_tag);
		box_class_t cls;
		priority if (box_tag == TAG_FTYP) cls = CLS_FTYP;
		else if (box_tag == TAG_MOOV) cls = CLS_MOOV;
		else if (box_tag == TAG_MOOF) cls = CLS_MOOF;
		else if (box_tag == TAG_MDAT) cls = CLS_MDAT;
		else if (box_tag == TAG_STYP || box_tag == TAG_SIDX ||
				box_tag == TAG_PRFT || box_tag == TAG_FREE) cls = CLS_LEAD;
		else cls = CLS_OTHER;
		return cls;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/fmbs_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// fmbs_in_if
// Byte stream channel into the splitter: valid, ready and one data byte.
// ---------------------------------------------------------------------------
interface fmbs_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface
`default_nettype wire

// ===== hdl/fmbs_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// fmbs_out_if
// Tagged byte channel out of the splitter: the byte and its segment flags.
// ---------------------------------------------------------------------------
interface fmbs_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       segment_kind;
	logic       segment_end;
	logic       discard;
	logic       malformed;

	modport source (output valid, output out_byte, output segment_kind,
		output segment_end, output discard, output malformed, input ready);
	modport sink (input valid, input out_byte, input segment_kind,
		input segment_end, input discard, input malformed, output ready);
endinterface
`default_nettype wire

// ===== hdl/fragmented_mp4_box_splitter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// fragmented_mp4_box_splitter
// Passes a fragmented MP4 byte stream through and tags every byte with its
// segment, the segment ends, discards and malformed box headers.
// ---------------------------------------------------------------------------
// Channel   Direction  Beat contents
// stream    in         data_byte
// result    out        out_byte, segment_kind, segment_end, discard, malformed
//
// One byte per clock while result does not stall: the box parser updates on
// every accepted beat and its tagged result lands in the output register as that beat is taken.
// The path that sets the rate is the 32-bit box length decrement and compare.
// The stream is taken whenever the output register is empty or being emptied
// in the same cycle, so a stall on result holds back stream only then.
// Reset (arst_n low) returns the parser to the init phase with no open box.
// ---------------------------------------------------------------------------
`include "fragmented_mp4_box_splitter_macros.svh"

module fragmented_mp4_box_splitter
	import fmbs_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	fmbs_in_if.sink    stream,
	fmbs_out_if.source result
);

	logic              frag_phase_q;
	logic              ftyp_found_q;
	logic              moov_found_q;
	logic              moof_found_q;
	logic [ShiftW-1:0] hdr_shift_q;
	hdr_cnt_t          hdr_cnt_q;
	box_len_t          box_left_q;
	box_class_t        box_class_q;

	logic              frag_phase_d;
	logic              ftyp_found_d;
	logic              moov_found_d;
	logic              moof_found_d;
	logic [ShiftW-1:0] hdr_shift_d;
	hdr_cnt_t          hdr_cnt_d;
	box_len_t          box_left_d;
	box_class_t        box_class_d;

	logic              seg_end;
	logic              disc;
	logic              bad;
	logic              complete;
	box_class_t        cls;

	box_len_t          hdr_size;
	box_tag_t          hdr_tag;

	logic              out_valid_q;
	logic [7:0]        out_byte_q;
	logic              out_kind_q;
	logic              out_end_q;
	logic              out_disc_q;
	logic              out_bad_q;

	logic              accept;

	// On the last header byte the size sits in the older shifted bytes and
	// the type is completed by the incoming byte.
	assign hdr_size = hdr_shift_q[ShiftW-1 -: 32];
	assign hdr_tag  = {hdr_shift_q[23:0], stream.data_byte};

	assign stream.ready = !out_valid_q || result.ready;
	assign accept       = stream.valid && stream.ready;

	always_comb begin
		frag_phase_d = frag_phase_q;
		ftyp_found_d = ftyp_found_q;
		moov_found_d = moov_found_q;
		moof_found_d = moof_found_q;
		hdr_shift_d  = hdr_shift_q;
		hdr_cnt_d    = hdr_cnt_q;
		box_left_d   = box_left_q;
		box_class_d  = box_class_q;
		seg_end      = 1'b0;
		disc         = 1'b0;
		bad          = 1'b0;
		complete     = 1'b0;
		cls          = box_class_q;

		if (hdr_cnt_q < HDR_DONE) begin
			hdr_shift_d = {hdr_shift_q[ShiftW-9:0], stream.data_byte};
			hdr_cnt_d   = hdr_cnt_q + hdr_cnt_t'(1);
			if (hdr_cnt_q == HDR_LAST) begin
				if (hdr_size < MIN_BOX) begin
					bad = 1'b1;
					disc = 1'b1;
					if (frag_phase_q) begin
						moof_found_d = 1'b0;
					end else begin
						ftyp_found_d = 1'b0;
						moov_found_d = 1'b0;
					end
					hdr_cnt_d   = '0;
					hdr_shift_d = '0;
					box_left_d  = '0;
					box_class_d = CLS_OTHER;
				end else begin
					cls         = classify(hdr_tag);
					box_class_d = cls;
					box_left_d  = hdr_size - MIN_BOX;
					complete    = (hdr_size == MIN_BOX);
				end
			end
		end else begin
			if (box_left_q != '0) begin
				box_left_d = box_left_q - box_len_t'(1);
			end
			complete = (box_left_q == box_len_t'(1)) || (box_left_q == '0);
		end

		if (complete) begin
			hdr_cnt_d   = '0;
			hdr_shift_d = '0;
			if (!frag_phase_q) begin
				if (!ftyp_found_q && cls == CLS_FTYP) begin
					ftyp_found_d = 1'b1;
				end else if (!moov_found_q && cls == CLS_MOOV) begin
					moov_found_d = 1'b1;
				end
				if (ftyp_found_d && moov_found_d) begin
					seg_end      = 1'b1;
					frag_phase_d = 1'b1;
					moof_found_d = 1'b0;
				end
			end else if (!moof_found_q) begin
				if (cls == CLS_MOOF) begin
					moof_found_d = 1'b1;
				end else if (cls != CLS_LEAD) begin
					disc = 1'b1;
				end
			end else if (cls == CLS_MDAT) begin
				seg_end      = 1'b1;
				moof_found_d = 1'b0;
			end
			box_class_d = CLS_OTHER;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frag_phase_q <= 1'b0;
			ftyp_found_q <= 1'b0;
			moov_found_q <= 1'b0;
			moof_found_q <= 1'b0;
			hdr_shift_q  <= '0;
			hdr_cnt_q    <= '0;
			box_left_q   <= '0;
			box_class_q  <= CLS_OTHER;
		end else if (accept) begin
			frag_phase_q <= frag_phase_d;
			ftyp_found_q <= ftyp_found_d;
			moov_found_q <= moov_found_d;
			moof_found_q <= moof_found_d;
			hdr_shift_q  <= hdr_shift_d;
			hdr_cnt_q    <= hdr_cnt_d;
			box_left_q   <= box_left_d;
			box_class_q  <= box_class_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_byte_q <= stream.data_byte;
			out_kind_q <= frag_phase_q;
			out_end_q  <= seg_end;
			out_disc_q <= disc;
			out_bad_q  <= bad;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.out_byte     = out_byte_q;
	assign result.segment_kind = out_kind_q;
	assign result.segment_end  = out_end_q;
	assign result.discard      = out_disc_q;
	assign result.malformed    = out_bad_q;

	// A beat taken in always leaves a result waiting on the next cycle.
	`FMBS_ASSERT_NEXT(a_accept_gives_result, clk, arst_n, accept, out_valid_q)
	// A byte flagged malformed is always flagged discard as well.
	`FMBS_ASSERT_SAME(a_malformed_discards, clk, arst_n, out_valid_q && out_bad_q, out_disc_q)
	// A segment is never both emitted and dropped on the same byte.
	`FMBS_ASSERT_SAME(a_end_not_discard, clk, arst_n, out_valid_q && out_end_q, !out_disc_q)
	// Once in fragment phase the parser never returns to init phase.
	`FMBS_ASSERT_SAME(a_phase_sticky, clk, arst_n, 1'b1, !$fell(frag_phase_q))
	// The header counter never runs past a full header.
	`FMBS_ASSERT_SAME(a_hdr_cnt_range, clk, arst_n, 1'b1, hdr_cnt_q <= HDR_DONE)

endmodule
`default_nettype wire
